// File: hdl/jacb_pkg.sv
`timescale 1ns / 1ps

package jacb_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FULL_SCALE  = 1024;
  localparam int WINDOW_HALF = 100;
  localparam int AXIS_W      = $clog2(FULL_SCALE + 1) + 1;

  localparam int BTN_W = 8;
  localparam int DZ_W  = 11;
  localparam logic [DZ_W-1:0] DZ_RESET = 11'd410;

  localparam int NUM_AXES = 4;

endpackage

// File: hdl/jacb_in_if.sv
`timescale 1ns / 1ps

interface jacb_in_if #(
  parameter int SAMPLE_BITS = jacb_pkg::SAMPLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic [jacb_pkg::BTN_W-1:0]   button_levels;
  logic [SAMPLE_BITS-1:0]       stick1_horizontal;
  logic [SAMPLE_BITS-1:0]       stick1_vertical;
  logic [SAMPLE_BITS-1:0]       stick2_horizontal;
  logic [SAMPLE_BITS-1:0]       stick2_vertical;

  modport source (
    output valid, button_levels, stick1_horizontal, stick1_vertical,
           stick2_horizontal, stick2_vertical,
    input  ready
  );

  modport sink (
    input  valid, button_levels, stick1_horizontal, stick1_vertical,
           stick2_horizontal, stick2_vertical,
    output ready
  );
endinterface

// File: hdl/jacb_out_if.sv
`timescale 1ns / 1ps

interface jacb_out_if #(
  parameter int AXIS_W = jacb_pkg::AXIS_W
);
  logic                         valid;
  logic                         ready;
  logic [jacb_pkg::BTN_W-1:0]   held_mask;
  logic [jacb_pkg::BTN_W-1:0]   pressed_mask;
  logic [jacb_pkg::BTN_W-1:0]   released_mask;
  logic                         levels_changed;
  logic signed [AXIS_W-1:0]     stick1_x;
  logic signed [AXIS_W-1:0]     stick1_y;
  logic signed [AXIS_W-1:0]     stick2_x;
  logic signed [AXIS_W-1:0]     stick2_y;
  logic                         stick1_active;

  modport source (
    output valid, held_mask, pressed_mask, released_mask, levels_changed,
           stick1_x, stick1_y, stick2_x, stick2_y, stick1_active,
    input  ready
  );

  modport sink (
    input  valid, held_mask, pressed_mask, released_mask, levels_changed,
           stick1_x, stick1_y, stick2_x, stick2_y, stick1_active,
    output ready
  );
endinterface

// File: hdl/jacb_lane.sv
`timescale 1ns / 1ps

module jacb_lane #(
  parameter int SAMPLE_BITS = jacb_pkg::SAMPLE_BITS,
  parameter int FULL_SCALE  = jacb_pkg::FULL_SCALE,
  parameter int AXIS_W      = $clog2(FULL_SCALE + 1) + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [SAMPLE_BITS-1:0]   sample,
  output logic                     done,
  output logic signed [AXIS_W-1:0] value
);

  localparam int QW = AXIS_W - 1;
  localparam int ND = SAMPLE_BITS + QW;
  localparam int CW = $clog2(ND + 1);
  localparam logic [SAMPLE_BITS-1:0] LOW_RST =
    SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - jacb_pkg::WINDOW_HALF);
  localparam logic [SAMPLE_BITS-1:0] HIGH_RST =
    SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) + jacb_pkg::WINDOW_HALF);
  localparam logic [ND-1:0] FULL_ND = ND'(FULL_SCALE);
  localparam logic [AXIS_W-1:0] FULL_AX = AXIS_W'(FULL_SCALE);
  localparam logic [CW-1:0] LAST_STEP = CW'(ND - 1);

  logic [SAMPLE_BITS-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [SAMPLE_BITS-1:0] span_r, span_nxt;
  logic [SAMPLE_BITS-1:0] rem_r, rem_nxt;
  logic [ND-1:0]          dvd_r, dvd_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [AXIS_W-1:0]      value_r, value_nxt;

  logic [SAMPLE_BITS-1:0] offset;
  logic [SAMPLE_BITS:0]   trial;
  logic                   fits;

  always_comb begin
    low_nxt   = low_r;
    high_nxt  = high_r;
    span_nxt  = span_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    value_nxt = value_r;
    offset    = '0;
    trial     = {rem_r, dvd_r[ND-1]};
    fits      = trial >= {1'b0, span_r};
    if (start) begin
      // widen the window, then load the divider
      if (sample < low_r) begin
        low_nxt = sample;
      end
      if (sample > high_r) begin
        high_nxt = sample;
      end
      offset   = sample - low_nxt;
      span_nxt = high_nxt - low_nxt;
      dvd_nxt  = ND'({{QW{1'b0}}, offset} * FULL_ND);
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? SAMPLE_BITS'(trial - {1'b0, span_r}) : trial[SAMPLE_BITS-1:0];
      dvd_nxt = {dvd_r[ND-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        value_nxt = {dvd_nxt[QW-1:0], 1'b0} - FULL_AX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_RST;
      high_r <= HIGH_RST;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r  <= span_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    value_r <= value_nxt;
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

// File: hdl/jacb_merge.sv
`timescale 1ns / 1ps

module jacb_merge #(
  parameter int AXIS_W = jacb_pkg::AXIS_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [AXIS_W-1:0]    lane_val [jacb_pkg::NUM_AXES],
  input  logic [jacb_pkg::DZ_W-1:0]   dead_zone,
  output logic signed [AXIS_W-1:0]    axis_val [jacb_pkg::NUM_AXES],
  output logic                        active,
  output logic                        done
);

  localparam int SQ_W  = 2 * AXIS_W;
  localparam int DSQ_W = 2 * jacb_pkg::DZ_W;
  localparam int CMP_W = (SQ_W + 1 > DSQ_W) ? SQ_W + 1 : DSQ_W;

  logic signed [AXIS_W-1:0] axis_r [jacb_pkg::NUM_AXES];
  logic signed [AXIS_W-1:0] axis_nxt [jacb_pkg::NUM_AXES];
  logic signed [SQ_W-1:0]   sqx_r, sqy_r;
  logic [DSQ_W-1:0]         dzsq_r;
  logic                     s1_r, done_r;
  logic                     active_r;
  logic [CMP_W-1:0]         len_sq, dz_sq;

  always_comb begin
    for (int i = 0; i < jacb_pkg::NUM_AXES; i++) begin
      axis_nxt[i] = lane_val[i];
    end
    // stick one vertical and stick two horizontal run the other way
    axis_nxt[1] = -lane_val[1];
    axis_nxt[2] = -lane_val[2];
    len_sq = CMP_W'($unsigned(sqx_r)) + CMP_W'($unsigned(sqy_r));
    dz_sq  = CMP_W'(dzsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      done_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      axis_r <= axis_nxt;
      sqx_r  <= SQ_W'(axis_nxt[0]) * SQ_W'(axis_nxt[0]);
      sqy_r  <= SQ_W'(axis_nxt[1]) * SQ_W'(axis_nxt[1]);
      dzsq_r <= DSQ_W'(dead_zone) * DSQ_W'(dead_zone);
    end
    if (s1_r) begin
      active_r <= len_sq > dz_sq;
    end
  end

  assign axis_val = axis_r;
  assign active   = active_r;
  assign done     = done_r;

endmodule

// File: hdl/joystick_autocal_button_edges.sv
`timescale 1ns / 1ps

// Joystick normalizer with button edge detection.
// in_ch carries one item per poll: eight active-low button levels and four
// raw stick samples. out_ch returns one result item per input item: held,
// pressed and released masks, a changed flag, four signed Q.10 axes and the
// stick one dead-zone flag. cfg_we/cfg_data write the dead-zone radius;
// write only while no item is in flight.
// Each axis has its own lane with a bit-serial restoring divider, one
// quotient bit per cycle over SAMPLE_BITS + clog2(FULL_SCALE+1) bits.
// The lanes feed a two-stage squaring merge, which feeds the output
// register. A new item is accepted only after the result of the last
// one has been loaded into the output register.
// in_ch.ready is high while idle, also while a finished result waits in the
// output register; if out_ch stalls the next result waits until it drains.
// Reset clears the button history to all released, sets every axis window
// to center +/- 100 and the dead zone to 410.
module joystick_autocal_button_edges #(
  parameter int SAMPLE_BITS = jacb_pkg::SAMPLE_BITS,
  parameter int FULL_SCALE  = jacb_pkg::FULL_SCALE,
  parameter int AXIS_W      = $clog2(FULL_SCALE + 1) + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  jacb_in_if.sink                    in_ch,
  jacb_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [jacb_pkg::DZ_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_LOAD
  } state_t;

  localparam int BW = jacb_pkg::BTN_W;
  localparam int NA = jacb_pkg::NUM_AXES;

  state_t                   state_r;
  logic [BW-1:0]            prev_r;
  logic [BW-1:0]            held_r, pressed_r, released_r;
  logic                     changed_r;
  logic [jacb_pkg::DZ_W-1:0] dz_r;
  logic                     out_valid_r;
  logic [BW-1:0]            o_held_r, o_pressed_r, o_released_r;
  logic                     o_changed_r, o_active_r;
  logic signed [AXIS_W-1:0] o_axis_r [NA];

  logic                     accept, slot_free, merge_done, merge_active, all_done;
  logic [SAMPLE_BITS-1:0]   samples [NA];
  logic                     lane_done [NA];
  logic signed [AXIS_W-1:0] lane_val [NA];
  logic signed [AXIS_W-1:0] axis_val [NA];
  logic                     load;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign samples[0] = in_ch.stick1_horizontal;
  assign samples[1] = in_ch.stick1_vertical;
  assign samples[2] = in_ch.stick2_horizontal;
  assign samples[3] = in_ch.stick2_vertical;

  for (genvar g = 0; g < NA; g++) begin : g_lane
    jacb_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FULL_SCALE  (FULL_SCALE),
      .AXIS_W      (AXIS_W)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (accept),
      .sample (samples[g]),
      .done   (lane_done[g]),
      .value  (lane_val[g])
    );
  end

  assign all_done = lane_done[0] && lane_done[1] && lane_done[2] && lane_done[3];

  jacb_merge #(
    .AXIS_W (AXIS_W)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (all_done),
    .lane_val  (lane_val),
    .dead_zone (dz_r),
    .axis_val  (axis_val),
    .active    (merge_active),
    .done      (merge_done)
  );

  assign load = ((state_r == ST_BUSY && merge_done) || state_r == ST_LOAD) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '1;
      dz_r        <= jacb_pkg::DZ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dz_r <= cfg_data;
      end
      if (accept) begin
        prev_r <= in_ch.button_levels;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (merge_done) begin
            state_r <= slot_free ? ST_IDLE : ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r     <= ~in_ch.button_levels;
      pressed_r  <= ~in_ch.button_levels & prev_r;
      released_r <= in_ch.button_levels & ~prev_r;
      changed_r  <= in_ch.button_levels != prev_r;
    end
    if (load) begin
      o_held_r     <= held_r;
      o_pressed_r  <= pressed_r;
      o_released_r <= released_r;
      o_changed_r  <= changed_r;
      o_axis_r     <= axis_val;
      o_active_r   <= merge_active;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.held_mask      = o_held_r;
  assign out_ch.pressed_mask   = o_pressed_r;
  assign out_ch.released_mask  = o_released_r;
  assign out_ch.levels_changed = o_changed_r;
  assign out_ch.stick1_x       = o_axis_r[0];
  assign out_ch.stick1_y       = o_axis_r[1];
  assign out_ch.stick2_x       = o_axis_r[2];
  assign out_ch.stick2_y       = o_axis_r[3];
  assign out_ch.stick1_active  = o_active_r;

endmodule

// File: bench/tb_joystick_autocal_button_edges.sv
`timescale 1ns / 1ps

module tb_joystick_autocal_button_edges;

  localparam int SAMPLE_BITS = jacb_pkg::SAMPLE_BITS;
  localparam int FULL_SCALE = jacb_pkg::FULL_SCALE;
  localparam int WINDOW_HALF = jacb_pkg::WINDOW_HALF;
  localparam int BTN_W = jacb_pkg::BTN_W;
  localparam int DZ_W = jacb_pkg::DZ_W;
  localparam logic [DZ_W-1:0] DZ_RESET = jacb_pkg::DZ_RESET;
  localparam int NUM_AXES = jacb_pkg::NUM_AXES;
  localparam int AXIS_W = $clog2(FULL_SCALE + 1) + 1;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int CENTRE = 1 << (SAMPLE_BITS - 1);
  localparam int NO_CFG = -1;
  localparam int RANDOM_DZ = -2;
  localparam int NUM_ROWS = 22;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 257;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRESSURE_AT = 150;
  localparam int PRESSURE_CYCLES = 800;
  localparam longint LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    logic [BTN_W-1:0]       buttons;
    logic [SAMPLE_BITS-1:0] s1h;
    logic [SAMPLE_BITS-1:0] s1v;
    logic [SAMPLE_BITS-1:0] s2h;
    logic [SAMPLE_BITS-1:0] s2v;
  } poll_item_t;

  typedef struct packed {
    logic [BTN_W-1:0]         held;
    logic [BTN_W-1:0]         pressed;
    logic [BTN_W-1:0]         released;
    logic                     changed;
    logic signed [AXIS_W-1:0] s1x;
    logic signed [AXIS_W-1:0] s1y;
    logic signed [AXIS_W-1:0] s2x;
    logic signed [AXIS_W-1:0] s2y;
    logic                     active;
  } poll_result_t;

  typedef struct {
    int           dz;
    poll_item_t   item;
    bit           typed;
    poll_result_t want;
  } directed_row_t;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [DZ_W-1:0] cfg_data;

  jacb_in_if  in_ch ();
  jacb_out_if out_ch ();

  joystick_autocal_button_edges DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  poll_result_t pending_results [$];
  int           mismatches;
  int           results_seen;
  longint       cycle_count;

  logic [BTN_W-1:0]       last_levels;
  logic [SAMPLE_BITS-1:0] win_lo [NUM_AXES];
  logic [SAMPLE_BITS-1:0] win_hi [NUM_AXES];
  logic [DZ_W-1:0]        dead_zone;

  directed_row_t directed_rows [NUM_ROWS] = '{
    '{NO_CFG, '{8'hFF, 10'd512, 10'd512, 10'd512, 10'd512}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 1'b0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0}},
    '{NO_CFG, '{8'hFE, 10'd412, 10'd612, 10'd412, 10'd612}, 1'b0, '0},
    '{NO_CFG, '{8'hFE, 10'd612, 10'd412, 10'd612, 10'd412}, 1'b0, '0},
    '{NO_CFG, '{8'h7F, 10'd411, 10'd613, 10'd411, 10'd613}, 1'b0, '0},
    '{NO_CFG, '{8'h80, 10'd300, 10'd700, 10'd450, 10'd560}, 1'b0, '0},
    '{NO_CFG, '{8'hAA, 10'd513, 10'd511, 10'd600, 10'd420}, 1'b0, '0},
    '{NO_CFG, '{8'h55, 10'd100, 10'd900, 10'd800, 10'd200}, 1'b0, '0},
    '{NO_CFG, '{8'h55, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{8'hAA, 8'h00, 8'h00, 1'b0, -12'sd1024, 12'sd1024, 12'sd1024, -12'sd1024, 1'b1}},
    '{NO_CFG, '{8'h00, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{8'hFF, 8'h55, 8'h00, 1'b1, -12'sd1024, 12'sd1024, 12'sd1024, -12'sd1024, 1'b1}},
    '{NO_CFG, '{8'hFF, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b1,
      '{8'h00, 8'h00, 8'hFF, 1'b1, 12'sd1024, -12'sd1024, -12'sd1024, 12'sd1024, 1'b1}},
    '{NO_CFG, '{8'hFF, 10'd512, 10'd512, 10'd512, 10'd512}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 1'b0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0}},
    '{0, '{8'hFF, 10'd512, 10'd512, 10'd512, 10'd512}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 1'b0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0}},
    '{NO_CFG, '{8'hFF, 10'd513, 10'd512, 10'd512, 10'd512}, 1'b0, '0},
    '{NO_CFG, '{8'hFF, 10'd512, 10'd511, 10'd512, 10'd512}, 1'b0, '0},
    '{1448, '{8'h0F, 10'd1023, 10'd0, 10'd512, 10'd512}, 1'b0, '0},
    '{NO_CFG, '{8'hF0, 10'd0, 10'd1023, 10'd1023, 10'd0}, 1'b0, '0},
    '{2047, '{8'h0F, 10'd1023, 10'd0, 10'd1023, 10'd1023}, 1'b0, '0},
    '{410, '{8'h0F, 10'd717, 10'd512, 10'd512, 10'd512}, 1'b0, '0},
    '{NO_CFG, '{8'h0F, 10'd718, 10'd512, 10'd0, 10'd1023}, 1'b0, '0},
    '{NO_CFG, '{8'h3C, 10'd512, 10'd306, 10'd512, 10'd512}, 1'b0, '0},
    '{NO_CFG, '{8'hC3, 10'd512, 10'd307, 10'd512, 10'd512}, 1'b0, '0},
    '{NO_CFG, '{8'hFF, 10'd1023, 10'd1023, 10'd0, 10'd0}, 1'b0, '0}
  };

  int dz_plan [NUM_PHASES] = '{0, RANDOM_DZ, 2047, 1448, RANDOM_DZ, 1, 410};

  function automatic int scale_axis(input int axis, input logic [SAMPLE_BITS-1:0] sample);
    int span;
    int mapped;
    if (sample < win_lo[axis]) win_lo[axis] = sample;
    if (sample > win_hi[axis]) win_hi[axis] = sample;
    span = int'(win_hi[axis]) - int'(win_lo[axis]);
    if (span == 0) mapped = 0;
    else mapped = ((int'(sample) - int'(win_lo[axis])) * FULL_SCALE) / span;
    return 2 * mapped - FULL_SCALE;
  endfunction

  function automatic poll_result_t predict_poll(input poll_item_t it);
    poll_result_t r;
    int           ax [NUM_AXES];
    longint       sq_len;
    longint       sq_dz;
    r.held     = ~it.buttons;
    r.pressed  = ~it.buttons & last_levels;
    r.released = it.buttons & ~last_levels;
    r.changed  = (it.buttons != last_levels);
    last_levels = it.buttons;
    ax[0] = scale_axis(0, it.s1h);
    ax[1] = -scale_axis(1, it.s1v);
    ax[2] = -scale_axis(2, it.s2h);
    ax[3] = scale_axis(3, it.s2v);
    r.s1x = ax[0][AXIS_W-1:0];
    r.s1y = ax[1][AXIS_W-1:0];
    r.s2x = ax[2][AXIS_W-1:0];
    r.s2y = ax[3][AXIS_W-1:0];
    sq_len = longint'(ax[0]) * ax[0] + longint'(ax[1]) * ax[1];
    sq_dz = longint'(dead_zone) * longint'(dead_zone);
    r.active = (sq_len > sq_dz);
    return r;
  endfunction

  function automatic int pick_idle();
    int p;
    p = $urandom_range(0, 19);
    if (p < 10) return 0;
    if (p < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    if (p < 8) return SAMPLE_BITS'($urandom_range(CENTRE - 132, CENTRE + 132));
    if (p == 8) return ($urandom_range(0, 1) != 0) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
    return SAMPLE_BITS'($urandom_range(700, 740));
  endfunction

  function automatic poll_item_t random_poll(input logic [BTN_W-1:0] prev_buttons);
    poll_item_t it;
    int         p;
    p = $urandom_range(0, 9);
    if (p < 5) it.buttons = BTN_W'($urandom_range(0, (1 << BTN_W) - 1));
    else if (p < 9) it.buttons = prev_buttons ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
    else it.buttons = prev_buttons;
    it.s1h = random_sample();
    it.s1v = random_sample();
    it.s2h = random_sample();
    it.s2v = random_sample();
    return it;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic send_poll(input poll_item_t it, input bit typed, input poll_result_t want);
    int           gap;
    poll_result_t exp;
    gap = pick_idle();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.button_levels     <= it.buttons;
    in_ch.stick1_horizontal <= it.s1h;
    in_ch.stick1_vertical   <= it.s1v;
    in_ch.stick2_horizontal <= it.s2h;
    in_ch.stick2_vertical   <= it.s2v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp = predict_poll(it);
    pending_results.push_back(typed ? want : exp);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dead_zone(input logic [DZ_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dead_zone = value;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int              ready_left;
    bit              pressure_done;
    poll_result_t    got;
    poll_result_t    want;
    ready_left    = 0;
    pressure_done = 0;
    results_seen  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.held_mask, out_ch.pressed_mask, out_ch.released_mask,
                out_ch.levels_changed, out_ch.stick1_x, out_ch.stick1_y,
                out_ch.stick2_x, out_ch.stick2_y, out_ch.stick1_active};
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item, expected none, actual held_mask %0h",
                   $time, got.held);
        end else begin
          want = pending_results.pop_front();
          check_field("held_mask", int'(want.held), int'(got.held));
          check_field("pressed_mask", int'(want.pressed), int'(got.pressed));
          check_field("released_mask", int'(want.released), int'(got.released));
          check_field("levels_changed", int'(want.changed), int'(got.changed));
          check_field("stick1_x", int'($signed(want.s1x)), int'($signed(got.s1x)));
          check_field("stick1_y", int'($signed(want.s1y)), int'($signed(got.s1y)));
          check_field("stick2_x", int'($signed(want.s2x)), int'($signed(got.s2x)));
          check_field("stick2_y", int'($signed(want.s2y)), int'($signed(got.s2y)));
          check_field("stick1_active", int'(want.active), int'(got.active));
        end
      end
      if (ready_left > 0) begin
        ready_left--;
      end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1;
        out_ch.ready <= 1'b0;
        ready_left = PRESSURE_CYCLES;
      end else if (out_ch.ready) begin
        out_ch.ready <= 1'b0;
        ready_left = pick_idle();
      end else begin
        out_ch.ready <= 1'b1;
        ready_left = $urandom_range(0, 30);
      end
    end
  end

  initial begin
    poll_item_t       it;
    logic [BTN_W-1:0] prev_buttons;
    int               dz;
    mismatches = 0;
    last_levels = '1;
    for (int a = 0; a < NUM_AXES; a++) begin
      win_lo[a] = SAMPLE_BITS'(CENTRE - WINDOW_HALF);
      win_hi[a] = SAMPLE_BITS'(CENTRE + WINDOW_HALF);
    end
    dead_zone = DZ_RESET;
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_data                <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.button_levels     <= '1;
    in_ch.stick1_horizontal <= '0;
    in_ch.stick1_vertical   <= '0;
    in_ch.stick2_horizontal <= '0;
    in_ch.stick2_vertical   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].dz != NO_CFG) begin
        settle();
        write_dead_zone(DZ_W'(directed_rows[i].dz));
      end
      send_poll(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    prev_buttons = directed_rows[NUM_ROWS-1].item.buttons;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      dz = (dz_plan[ph] == RANDOM_DZ) ? $urandom_range(0, (1 << DZ_W) - 1) : dz_plan[ph];
      write_dead_zone(DZ_W'(dz));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = random_poll(prev_buttons);
        prev_buttons = it.buttons;
        send_poll(it, 1'b0, '0);
      end
    end
    settle();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/jacb_pkg.sv
hdl/jacb_in_if.sv
hdl/jacb_out_if.sv
hdl/jacb_lane.sv
hdl/jacb_merge.sv
hdl/joystick_autocal_button_edges.sv
bench/tb_joystick_autocal_button_edges.sv
